/* src/ovm_pkg.sv */
// ----------------------------------------------------------------------------
// Obstacle velocity modulation package
// Shared constants, operation codes and arithmetic helpers.
// ----------------------------------------------------------------------------
package ovm_pkg;

  localparam logic [1:0] OpBegin = 2'd0;
  localparam logic [1:0] OpObstacle = 2'd1;
  localparam logic [1:0] OpPose = 2'd2;

  localparam logic [1:0] CfgGoalX = 2'd0;
  localparam logic [1:0] CfgGoalY = 2'd1;
  localparam logic [1:0] CfgSafeRange = 2'd2;

  localparam int DivSteps = 31;

  localparam logic signed [31:0] OneQ30 = 32'sd1073741824;
  localparam logic signed [23:0] ThrustLim = 24'sd327680;
  localparam logic signed [25:0] FinLim = 26'sd411566;

  localparam logic signed [31:0] GoalXReset = 32'sd2621440;
  localparam logic signed [31:0] GoalYReset = 32'sd0;
  localparam logic [30:0] SafeRangeReset = 31'd983040;

  function automatic logic [3:0] idx3(input logic [1:0] row, input logic [1:0] col);
    idx3 = 4'(row) * 4'd3 + 4'(col);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
    if (x > 40'sd2147483647) begin
      sat32 = 32'sh7fffffff;
    end else if (x < -40'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = x[31:0];
    end
  endfunction

endpackage

/* src/ovm_div.sv */
// ----------------------------------------------------------------------------
// Fractional divider
// Restoring divider giving floor(num * 2^30 / den) for num <= den, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module ovm_div
  import ovm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [30:0] num,
  input  logic [30:0] den,
  output logic        done,
  output logic [30:0] quo
);

  logic [30:0] rem;
  logic [30:0] den_r;
  logic [4:0] cnt;
  logic busy;
  logic [31:0] t;
  logic ge;

  always_comb begin
    t = (cnt == 5'd0) ? {1'b0, rem} : {rem, 1'b0};
    ge = t >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem <= num;
        den_r <= den;
        cnt <= 5'd0;
        quo <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? 31'(t - {1'b0, den_r}) : t[30:0];
        quo <= {quo[29:0], ge};
        cnt <= cnt + 5'd1;
        if (cnt == 5'(DivSteps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* src/obstacle_velocity_modulation.sv */
// ----------------------------------------------------------------------------
// Obstacle velocity modulation
// Accumulates a 3x3 modulation matrix from obstacle transactions and maps the
// unit vector toward the goal through it into thrust and fin commands.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time. A begin-scan or ignored
// transaction is finished without leaving idle; an obstacle inside the safe
// range runs the serial divider with its start and done handshake, the
// squared ratio, passes of the shared multiplier for the filter matrix and
// the matrix product, and a copy of the product back; a pose runs
// normalization shifts, two squares, 31 square root steps, two divisions and
// four multiplies, all set by the one shared multiplier and the bit-serial
// divider and square root.
module obstacle_velocity_modulation
  import ovm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         operation,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  input  logic [30:0]        obstacle_range,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [19:0] thrust,
  output logic signed [19:0] fin
);

  localparam logic [4:0] StIdle = 5'd0;
  localparam logic [4:0] StDivR = 5'd1;
  localparam logic [4:0] StK = 5'd2;
  localparam logic [4:0] StF = 5'd3;
  localparam logic [4:0] StMm = 5'd4;
  localparam logic [4:0] StCopy = 5'd5;
  localparam logic [4:0] StNorm = 5'd6;
  localparam logic [4:0] StSq0 = 5'd7;
  localparam logic [4:0] StSq1 = 5'd8;
  localparam logic [4:0] StSqrt = 5'd9;
  localparam logic [4:0] StDivX = 5'd10;
  localparam logic [4:0] StDivY = 5'd11;
  localparam logic [4:0] StV0 = 5'd12;
  localparam logic [4:0] StV1 = 5'd13;
  localparam logic [4:0] StV2 = 5'd14;
  localparam logic [4:0] StV3 = 5'd15;

  logic [4:0] state;
  logic signed [31:0] goal_x;
  logic signed [31:0] goal_y;
  logic [30:0] safe_range;
  logic signed [31:0] m_q [9];
  logic signed [31:0] f_q [9];
  logic signed [31:0] res_q [9];
  logic signed [15:0] nx, ny, nz;
  logic [29:0] k;
  logic signed [31:0] p1;
  logic signed [37:0] acc;
  logic [1:0] ci, cj, cm;
  logic ph;
  logic signed [32:0] cx, cy;
  logic [59:0] sq;
  logic [61:0] sx, sr, sb;
  logic signed [31:0] ux, uy;
  logic signed [66:0] vacc;
  logic signed [22:0] vx;
  logic div_start;
  logic [30:0] div_num, div_den;
  logic div_done;
  logic [30:0] div_quo;

  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  logic signed [15:0] ni, nj;
  logic signed [37:0] acc_next;
  logic signed [39:0] f_val;
  logic [32:0] ax, ay, mag;
  logic [61:0] st;
  logic [61:0] sr_next;
  logic signed [66:0] vsum;
  logic signed [22:0] vy;
  logic signed [23:0] nvx, thr;
  logic signed [25:0] f5, fcl, fneg;

  ovm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  function automatic logic signed [15:0] nsel(input logic [1:0] s,
      input logic signed [15:0] a, input logic signed [15:0] b,
      input logic signed [15:0] c);
    case (s)
      2'd0: nsel = a;
      2'd1: nsel = b;
      default: nsel = c;
    endcase
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready = (state == StIdle);

  always_comb begin
    ni = nsel(ci, nx, ny, nz);
    nj = nsel(cj, nx, ny, nz);
    ma = '0;
    mb = '0;
    case (state)
      StK: begin
        ma = $signed({2'b00, div_quo});
        mb = $signed({2'b00, div_quo});
      end
      StF: begin
        if (!ph) begin
          ma = 33'(ni);
          mb = 33'(nj);
        end else begin
          ma = $signed({3'b000, k});
          mb = 33'(p1);
        end
      end
      StMm: begin
        ma = 33'(m_q[idx3(ci, cm)]);
        mb = 33'(f_q[idx3(cm, cj)]);
      end
      StSq0: begin
        ma = cx;
        mb = cx;
      end
      StSq1: begin
        ma = cy;
        mb = cy;
      end
      StV0: begin
        ma = 33'(m_q[0]);
        mb = 33'(ux);
      end
      StV1: begin
        ma = 33'(m_q[1]);
        mb = 33'(uy);
      end
      StV2: begin
        ma = 33'(m_q[3]);
        mb = 33'(ux);
      end
      StV3: begin
        ma = 33'(m_q[4]);
        mb = 33'(uy);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod = ma * mb;

  always_comb begin
    acc_next = ((cm == 2'd0) ? 38'sd0 : acc) + 38'($signed(prod[65:30]));
    f_val = ((ci == cj) ? 40'(OneQ30) : 40'sd0) - 40'($signed(prod[65:28]));
    ax = cx[32] ? 33'(-cx) : 33'(cx);
    ay = cy[32] ? 33'(-cy) : 33'(cy);
    mag = (ax > ay) ? ax : ay;
    st = sr + sb;
    sr_next = (sx >= st) ? ((sr >> 1) + sb) : (sr >> 1);
    vsum = vacc + 67'(prod);
    vy = vsum[66:44];
    nvx = -24'(vx);
    if (nvx > ThrustLim) begin
      thr = ThrustLim;
    end else if (nvx < -ThrustLim) begin
      thr = -ThrustLim;
    end else begin
      thr = nvx;
    end
    f5 = (26'(vy) <<< 2) + 26'(vy);
    if (f5 > FinLim) begin
      fcl = FinLim;
    end else if (f5 < -FinLim) begin
      fcl = -FinLim;
    end else begin
      fcl = f5;
    end
    fneg = -fcl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      div_start <= 1'b0;
      out_valid <= 1'b0;
      goal_x <= GoalXReset;
      goal_y <= GoalYReset;
      safe_range <= SafeRangeReset;
      for (int i = 0; i < 9; i++) begin
        m_q[i] <= (i % 4 == 0) ? OneQ30 : 32'sd0;
      end
    end else begin
      div_start <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_index)
          CfgGoalX: goal_x <= $signed(cfg_data);
          CfgGoalY: goal_y <= $signed(cfg_data);
          CfgSafeRange: safe_range <= cfg_data[30:0];
          default: ;
        endcase
      end
      case (state)
        StIdle: begin
          if (in_valid) begin
            case (operation)
              OpBegin: begin
                for (int i = 0; i < 9; i++) begin
                  m_q[i] <= (i % 4 == 0) ? OneQ30 : 32'sd0;
                end
              end
              OpObstacle: begin
                if (obstacle_range < safe_range) begin
                  nx <= normal_x;
                  ny <= normal_y;
                  nz <= normal_z;
                  div_num <= obstacle_range;
                  div_den <= safe_range;
                  div_start <= 1'b1;
                  state <= StDivR;
                end
              end
              OpPose: begin
                cx <= 33'(goal_x) - 33'(pos_x);
                cy <= 33'(goal_y) - 33'(pos_y);
                state <= StNorm;
              end
              default: ;
            endcase
          end
        end
        StDivR: begin
          if (div_done) begin
            state <= StK;
          end
        end
        StK: begin
          k <= prod[59:30];
          ci <= 2'd0;
          cj <= 2'd0;
          ph <= 1'b0;
          state <= StF;
        end
        StF: begin
          if (!ph) begin
            p1 <= prod[31:0];
            ph <= 1'b1;
          end else begin
            f_q[idx3(ci, cj)] <= sat32(f_val);
            ph <= 1'b0;
            if (cj == 2'd2) begin
              cj <= 2'd0;
              if (ci == 2'd2) begin
                ci <= 2'd0;
                cm <= 2'd0;
                state <= StMm;
              end else begin
                ci <= ci + 2'd1;
              end
            end else begin
              cj <= cj + 2'd1;
            end
          end
        end
        StMm: begin
          acc <= acc_next;
          if (cm == 2'd2) begin
            cm <= 2'd0;
            res_q[idx3(ci, cj)] <= sat32(40'(acc_next));
            if (cj == 2'd2) begin
              cj <= 2'd0;
              if (ci == 2'd2) begin
                state <= StCopy;
              end else begin
                ci <= ci + 2'd1;
              end
            end else begin
              cj <= cj + 2'd1;
            end
          end else begin
            cm <= cm + 2'd1;
          end
        end
        StCopy: begin
          for (int i = 0; i < 9; i++) begin
            m_q[i] <= res_q[i];
          end
          state <= StIdle;
        end
        StNorm: begin
          if (mag == 33'd0) begin
            ux <= 32'sd0;
            uy <= 32'sd0;
            state <= StV0;
          end else if (mag >= 33'd1073741824) begin
            cx <= cx >>> 1;
            cy <= cy >>> 1;
          end else if (mag < 33'd536870912) begin
            cx <= cx <<< 1;
            cy <= cy <<< 1;
          end else begin
            state <= StSq0;
          end
        end
        StSq0: begin
          sq <= prod[59:0];
          state <= StSq1;
        end
        StSq1: begin
          sx <= 62'(sq) + 62'(prod[59:0]);
          sr <= '0;
          sb <= 62'd1 << 60;
          state <= StSqrt;
        end
        StSqrt: begin
          if (sx >= st) begin
            sx <= sx - st;
          end
          sr <= sr_next;
          sb <= sb >> 2;
          if (sb == 62'd1) begin
            div_num <= ax[30:0];
            div_den <= sr_next[30:0];
            div_start <= 1'b1;
            state <= StDivX;
          end
        end
        StDivX: begin
          if (div_done) begin
            ux <= cx[32] ? -32'(div_quo) : 32'(div_quo);
            div_num <= ay[30:0];
            div_start <= 1'b1;
            state <= StDivY;
          end
        end
        StDivY: begin
          if (div_done) begin
            uy <= cy[32] ? -32'(div_quo) : 32'(div_quo);
            state <= StV0;
          end
        end
        StV0: begin
          vacc <= 67'(prod);
          state <= StV1;
        end
        StV1: begin
          vx <= vsum[66:44];
          state <= StV2;
        end
        StV2: begin
          vacc <= 67'(prod);
          state <= StV3;
        end
        StV3: begin
          if (!out_valid || out_ready) begin
            thrust <= thr[19:0];
            fin <= fneg[19:0];
            out_valid <= 1'b1;
            state <= StIdle;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end

endmodule
